/* rtl/page_frame_bitmap_allocator_top_defines.svh */
// Assertion macros for the page frame bitmap allocator.
// Included by the top level; uses its clk and arst_n.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define PFBA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pfba assertion failed");

// next-cycle implication
`define PFBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pfba assertion failed");

`endif

/* rtl/pfba_pkg.sv */
// Shared constants, types and helpers of the page frame bitmap allocator.
// No dependencies.
`default_nettype none
package pfba_pkg;
	localparam int MAX_FRAMES = 65536;
	localparam int PAGE_BYTES = 4096;
	localparam int ADDR_BITS  = 48;
	localparam int WORD_BITS  = 64;
	localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;
	localparam int WIDX_W     = $clog2(MAP_WORDS);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int FIDX_W     = WIDX_W + BIT_W;
	localparam int CNT_W      = 17;
	localparam int PG_W       = $clog2(PAGE_BYTES);
	localparam int BASE_W     = ADDR_BITS - PG_W;
	localparam int KIND_W     = 3;
	localparam int DIV_STEPS  = CNT_W;
	localparam int DCNT_W     = $clog2(DIV_STEPS);

	localparam logic [KIND_W-1:0] K_MARK_USED  = 3'd0;
	localparam logic [KIND_W-1:0] K_MARK_FREE  = 3'd1;
	localparam logic [KIND_W-1:0] K_ALLOC_ONE  = 3'd2;
	localparam logic [KIND_W-1:0] K_ALLOC_RUN  = 3'd3;
	localparam logic [KIND_W-1:0] K_FREE_RANGE = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0]    req_type;
		logic [ADDR_BITS-1:0] phys_addr;
		logic [CNT_W-1:0]     frame_count;
	} req_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] frame_addr;
		logic                 status;
	} res_t;

	typedef struct packed {
		logic load;
		logic clr_wr;
		logic div_step;
		logic fill_wr;
		logic one_eval;
		logic run_word;
		logic run_bit;
		logic set_oom;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_fill;
		logic is_one;
		logic is_run;
		logic oom_now;
		logic div_done;
		logic fill_last;
		logic found;
		logic scan_last;
		logic word_skip;
		logic word_last;
		logic bit_found;
		logic bit_last;
	} sts_t;

	typedef enum logic [11:0] {
		S_CLEAR = 12'b0000_0000_0001,
		S_IDLE  = 12'b0000_0000_0010,
		S_DEC   = 12'b0000_0000_0100,
		S_DIV   = 12'b0000_0000_1000,
		S_ORD   = 12'b0000_0001_0000,
		S_OEV   = 12'b0000_0010_0000,
		S_FRD   = 12'b0000_0100_0000,
		S_FEV   = 12'b0000_1000_0000,
		S_RRD   = 12'b0001_0000_0000,
		S_REV   = 12'b0010_0000_0000,
		S_RBIT  = 12'b0100_0000_0000,
		S_DONE  = 12'b1000_0000_0000
	} state_t;

	function automatic logic [BIT_W-1:0] ffs(input logic [WORD_BITS-1:0] v);
		logic [BIT_W-1:0] p;
		p = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) p = BIT_W'(i);
		end
		return p;
	endfunction
endpackage
`default_nettype wire

/* rtl/pfba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pfba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* rtl/pfba_ctrl.sv */
// Controller state machine of the page frame bitmap allocator.
// Depends on pfba_pkg.
`default_nettype none
module pfba_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire pfba_pkg::sts_t sts,
	output pfba_pkg::cmd_t     cmd,
	output logic               busy,
	output logic               done
);
	pfba_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pfba_pkg::S_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			pfba_pkg::S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) state_d = pfba_pkg::S_IDLE;
			end
			pfba_pkg::S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = pfba_pkg::S_DEC;
				end
			end
			pfba_pkg::S_DEC: begin
				if (sts.oom_now) begin
					cmd.set_oom = 1'b1;
					state_d = pfba_pkg::S_DONE;
				end else if (sts.is_fill) state_d = pfba_pkg::S_FRD;
				else if (sts.is_one) state_d = pfba_pkg::S_DIV;
				else if (sts.is_run) state_d = pfba_pkg::S_RRD;
				else state_d = pfba_pkg::S_DONE;
			end
			pfba_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) state_d = pfba_pkg::S_ORD;
			end
			pfba_pkg::S_ORD: state_d = pfba_pkg::S_OEV;
			pfba_pkg::S_OEV: begin
				cmd.one_eval = 1'b1;
				if (sts.found) state_d = pfba_pkg::S_DONE;
				else if (sts.scan_last) begin
					cmd.set_oom = 1'b1;
					state_d = pfba_pkg::S_DONE;
				end else state_d = pfba_pkg::S_ORD;
			end
			pfba_pkg::S_FRD: state_d = pfba_pkg::S_FEV;
			pfba_pkg::S_FEV: begin
				cmd.fill_wr = 1'b1;
				state_d = sts.fill_last ? pfba_pkg::S_DONE : pfba_pkg::S_FRD;
			end
			pfba_pkg::S_RRD: state_d = pfba_pkg::S_REV;
			pfba_pkg::S_REV: begin
				cmd.run_word = 1'b1;
				if (!sts.word_skip) state_d = pfba_pkg::S_RBIT;
				else if (sts.word_last) begin
					cmd.set_oom = 1'b1;
					state_d = pfba_pkg::S_DONE;
				end else state_d = pfba_pkg::S_RRD;
			end
			pfba_pkg::S_RBIT: begin
				cmd.run_bit = 1'b1;
				if (sts.bit_found) state_d = pfba_pkg::S_FRD;
				else if (sts.bit_last) begin
					if (sts.word_last) begin
						cmd.set_oom = 1'b1;
						state_d = pfba_pkg::S_DONE;
					end else state_d = pfba_pkg::S_RRD;
				end
			end
			pfba_pkg::S_DONE: state_d = pfba_pkg::S_IDLE;
			default: state_d = pfba_pkg::S_CLEAR;
		endcase
	end

	assign busy = (state_q != pfba_pkg::S_IDLE);
	assign done = (state_q == pfba_pkg::S_DONE);
endmodule
`default_nettype wire

/* rtl/pfba_datapath.sv */
// Datapath of the page frame bitmap allocator: bitmap RAM, pointer,
// remainder unit, word scan and fill logic. Depends on pfba_pkg, pfba_ram.
`default_nettype none
module pfba_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire pfba_pkg::cmd_t             cmd,
	output pfba_pkg::sts_t                  sts,
	input  wire pfba_pkg::req_t             req,
	input  wire logic                       cfg_we,
	input  wire logic [pfba_pkg::CNT_W-1:0] cfg_wdata,
	output pfba_pkg::res_t                  res
);
	localparam int W  = pfba_pkg::WORD_BITS;
	localparam int BW = pfba_pkg::BIT_W;
	localparam int IW = pfba_pkg::WIDX_W;
	localparam int FW = pfba_pkg::FIDX_W;
	localparam int CW = pfba_pkg::CNT_W;
	localparam logic [W-1:0] ONES = {W{1'b1}};
	localparam logic [BW-1:0] TOPBIT = BW'(W - 1);

	logic [CW-1:0] tracked_q, ptr_q;
	logic [IW-1:0] w_q;
	logic [IW:0]   k_q;
	logic [pfba_pkg::KIND_W-1:0] kind_q;
	logic [CW-1:0] cnt_q, hi_q, rem_q, run_q;
	logic [FW-1:0] lo_q, start_q, rstart_q;
	logic          set_q, has_fill_q, oom_q;
	logic [pfba_pkg::DCNT_W-1:0] dcnt_q;
	logic [W-1:0]  wd_q;
	logic [BW-1:0] b_q;
	logic [pfba_pkg::ADDR_BITS-1:0] addr_q;

	logic [W-1:0]  rd, wdata;
	logic          we;
	logic [CW-1:0] n, nm1, hm;
	logic [IW-1:0] last_w, w_adv;
	logic [IW:0]   nwords;
	logic [W-1:0]  vmask;

	// request decode
	logic [pfba_pkg::BASE_W-1:0] in_base;
	logic          in_ok;
	logic [CW:0]   in_sum;
	logic [CW-1:0] in_hi;
	logic          ld_fill;
	logic [CW-1:0] ld_hi;

	// fill
	logic [BW-1:0] lo_b, hi_b;
	logic [W-1:0]  fmask, fword;

	// alloc one
	logic [W-1:0]  smask, omask, cand;
	logic [BW-1:0] p;
	logic [FW-1:0] oidx;
	logic [CW-1:0] oidx1;

	// remainder
	logic [CW:0]   trial, rem_nx;

	// run scan
	logic [W-1:0]  rm;
	logic          allused, allfree, skip, bused, rhit;
	logic [CW:0]   rsum;
	logic [FW-1:0] rs;

	pfba_ram #(.WIDTH(W), .DEPTH(pfba_pkg::MAP_WORDS)) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(w_q),
		.wdata(wdata),
		.raddr(w_q),
		.rdata(rd)
	);

	assign n = (tracked_q > CW'(pfba_pkg::MAX_FRAMES)) ? CW'(pfba_pkg::MAX_FRAMES) : tracked_q;
	assign nm1 = n - CW'(1);
	assign last_w = nm1[FW-1:BW];
	assign nwords = (IW+1)'(last_w) + (IW+1)'(1);
	assign vmask = (w_q == last_w) ? (ONES >> (TOPBIT - nm1[BW-1:0])) : ONES;
	assign w_adv = (w_q == last_w) ? '0 : w_q + IW'(1);

	assign in_base = req.phys_addr[pfba_pkg::ADDR_BITS-1:pfba_pkg::PG_W];
	assign in_ok = in_base < pfba_pkg::BASE_W'(n);
	assign in_sum = (CW+1)'(in_base[FW-1:0]) + (CW+1)'(req.frame_count);
	assign in_hi = (in_sum > (CW+1)'(n)) ? n : in_sum[CW-1:0];

	always_comb begin
		ld_fill = 1'b0;
		ld_hi = CW'(in_base[FW-1:0]) + CW'(1);
		case (req.req_type)
			pfba_pkg::K_MARK_USED, pfba_pkg::K_MARK_FREE: ld_fill = in_ok;
			pfba_pkg::K_FREE_RANGE: begin
				ld_fill = in_ok && (req.frame_count != '0);
				ld_hi = in_hi;
			end
			default: ld_fill = 1'b0;
		endcase
	end

	assign hm = hi_q - CW'(1);
	assign lo_b = (w_q == lo_q[FW-1:BW]) ? lo_q[BW-1:0] : '0;
	assign hi_b = (w_q == hm[FW-1:BW]) ? hm[BW-1:0] : TOPBIT;
	assign fmask = (ONES << lo_b) & (ONES >> (TOPBIT - hi_b));
	assign fword = set_q ? (rd | fmask) : (rd & ~fmask);

	assign smask = ONES << start_q[BW-1:0];
	assign omask = vmask & ((k_q == '0) ? smask : ONES) & ((k_q == nwords) ? ~smask : ONES);
	assign cand = ~rd & omask;
	assign p = pfba_pkg::ffs(cand);
	assign oidx = {w_q, p};
	assign oidx1 = CW'(oidx) + CW'(1);

	assign trial = {rem_q, ptr_q[pfba_pkg::DCNT_W'(pfba_pkg::DIV_STEPS - 1) - dcnt_q]};
	assign rem_nx = (trial >= (CW+1)'(n)) ? (trial - (CW+1)'(n)) : trial;

	assign rm = rd | ~vmask;
	assign allused = &rm;
	assign allfree = ~|rm;
	assign rsum = (CW+1)'(run_q) + (CW+1)'(W);
	assign skip = allused || (allfree && (rsum < (CW+1)'(cnt_q)));
	assign bused = wd_q[b_q];
	assign rs = (run_q == '0) ? {w_q, b_q} : rstart_q;
	assign rhit = !bused && (((CW+1)'(run_q) + (CW+1)'(1)) == (CW+1)'(cnt_q));

	assign we = cmd.clr_wr || cmd.fill_wr || (cmd.one_eval && (|cand));
	assign wdata = cmd.clr_wr ? ONES : (cmd.fill_wr ? fword : (rd | (W'(1) << p)));

	always_comb begin
		sts = '0;
		sts.clr_last  = &w_q;
		sts.is_fill   = has_fill_q;
		sts.is_one    = kind_q == pfba_pkg::K_ALLOC_ONE;
		sts.is_run    = (kind_q == pfba_pkg::K_ALLOC_RUN) && (cnt_q != '0);
		sts.oom_now   = (sts.is_one && (n == '0)) || (sts.is_run && (cnt_q > n));
		sts.div_done  = dcnt_q == pfba_pkg::DCNT_W'(pfba_pkg::DIV_STEPS - 1);
		sts.fill_last = w_q == hm[FW-1:BW];
		sts.found     = |cand;
		sts.scan_last = k_q == nwords;
		sts.word_skip = skip;
		sts.word_last = w_q == last_w;
		sts.bit_found = rhit;
		sts.bit_last  = b_q == TOPBIT;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracked_q <= CW'(pfba_pkg::MAX_FRAMES);
			ptr_q <= '0;
			w_q <= '0;
		end else begin
			if (cfg_we) tracked_q <= cfg_wdata;
			if (cmd.clr_wr) w_q <= w_q + IW'(1);
			if (cmd.load) w_q <= ld_fill ? in_base[FW-1:BW] : '0;
			if (cmd.div_step && sts.div_done) w_q <= rem_nx[FW-1:BW];
			if (cmd.fill_wr) w_q <= w_q + IW'(1);
			if (cmd.one_eval) begin
				if (|cand) ptr_q <= (oidx1 == n) ? '0 : oidx1;
				else w_q <= w_adv;
			end
			if (cmd.run_word && skip) w_q <= w_q + IW'(1);
			if (cmd.run_bit) begin
				if (rhit) begin
					ptr_q <= CW'(rs) + cnt_q;
					w_q <= rs[FW-1:BW];
				end else if (b_q == TOPBIT) w_q <= w_q + IW'(1);
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req.req_type;
			cnt_q <= req.frame_count;
			lo_q <= in_base[FW-1:0];
			hi_q <= ld_hi;
			set_q <= req.req_type == pfba_pkg::K_MARK_USED;
			has_fill_q <= ld_fill;
			oom_q <= 1'b0;
			addr_q <= '0;
			rem_q <= '0;
			dcnt_q <= '0;
			run_q <= '0;
			k_q <= '0;
		end
		if (cmd.set_oom) oom_q <= 1'b1;
		if (cmd.div_step) begin
			rem_q <= rem_nx[CW-1:0];
			dcnt_q <= dcnt_q + pfba_pkg::DCNT_W'(1);
			if (sts.div_done) start_q <= rem_nx[FW-1:0];
		end
		if (cmd.one_eval) begin
			k_q <= k_q + (IW+1)'(1);
			if (|cand) addr_q <= pfba_pkg::ADDR_BITS'(oidx) << pfba_pkg::PG_W;
		end
		if (cmd.run_word) begin
			wd_q <= rm;
			b_q <= '0;
			if (allused) run_q <= '0;
			else if (skip) begin
				if (run_q == '0) rstart_q <= {w_q, BW'(0)};
				run_q <= rsum[CW-1:0];
			end
		end
		if (cmd.run_bit) begin
			b_q <= b_q + BW'(1);
			if (bused) run_q <= '0;
			else begin
				rstart_q <= rs;
				run_q <= run_q + CW'(1);
			end
			if (rhit) begin
				lo_q <= rs;
				hi_q <= CW'(rs) + cnt_q;
				set_q <= 1'b1;
				addr_q <= pfba_pkg::ADDR_BITS'(rs) << pfba_pkg::PG_W;
			end
		end
	end

	assign res.frame_addr = addr_q;
	assign res.status = oom_q;
endmodule
`default_nettype wire

/* rtl/page_frame_bitmap_allocator_top.sv */
// Top level of the page frame bitmap allocator: controller plus datapath.
// Depends on pfba_pkg, pfba_ctrl, pfba_datapath, the defines header.
//
//   channel  | handshake          | payload
//   request  | start, busy        | req (req_t)
//   result   | done (strobe)      | res (res_t)
//   config   | cfg_we             | cfg_wdata (tracked frames)
//
// After reset the bitmap RAM is filled with ones, one 64-bit word a cycle;
// busy stays high until the last word is written. Mark requests rewrite one
// word, skipped when the frame is out of range; free-range rewrites each word
// touched. Allocate-one runs the remainder unit, then scans word by word.
// Allocate-run scans words, walks the bits of each partly used word, then fills.
// The result is a one-cycle done strobe; the receiver cannot stall it.
`default_nettype none
`include "page_frame_bitmap_allocator_top_defines.svh"
module page_frame_bitmap_allocator_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire pfba_pkg::req_t             req,
	output logic                            busy,
	output logic                            done,
	output pfba_pkg::res_t                  res,
	input  wire logic                       cfg_we,
	input  wire logic [pfba_pkg::CNT_W-1:0] cfg_wdata
);
	pfba_pkg::cmd_t cmd;
	pfba_pkg::sts_t sts;

	pfba_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	pfba_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.res      (res)
	);

	`PFBA_ASSERT_NEXT(a_done_single, done, !done)
	`PFBA_ASSERT_NOW(a_done_busy, done, busy)
	`PFBA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`PFBA_ASSERT_NOW(a_oom_zero, done && res.status, res.frame_addr == '0)
endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for page_frame_bitmap_allocator_top.
// Drives random and directed requests, predicts results from a local bitmap model.
// Depends on pfba_pkg and the RTL top level.
`default_nettype none
module testbench;
	localparam longint CYCLE_LIMIT = 64'd200000000;

	logic clk;
	logic arst_n;
	logic start;
	pfba_pkg::req_t req;
	logic busy;
	logic done;
	pfba_pkg::res_t res;
	logic cfg_we;
	logic [pfba_pkg::CNT_W-1:0] cfg_wdata;

	bit used_map [pfba_pkg::MAX_FRAMES];
	int unsigned search_ptr;
	int unsigned tracked;
	pfba_pkg::res_t expected_res [$];
	int errors = 0;
	longint cycles = 0;

	page_frame_bitmap_allocator_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic pfba_pkg::res_t predict_alloc(pfba_pkg::req_t r);
		pfba_pkg::res_t o;
		longint unsigned base;
		int unsigned n, cnt, st, idx, run, rs;
		o = '0;
		n = (tracked < pfba_pkg::MAX_FRAMES) ? tracked : pfba_pkg::MAX_FRAMES;
		base = r.phys_addr / pfba_pkg::PAGE_BYTES;
		cnt = r.frame_count;
		case (r.req_type)
			pfba_pkg::K_MARK_USED, pfba_pkg::K_MARK_FREE: begin
				if (base < n) used_map[base] = (r.req_type == pfba_pkg::K_MARK_USED);
			end
			pfba_pkg::K_ALLOC_ONE: begin
				o.status = 1'b1;
				st = n ? search_ptr % n : 0;
				for (int unsigned i = 0; i < n; i++) begin
					idx = st + i;
					if (idx >= n) idx -= n;
					if (!used_map[idx]) begin
						used_map[idx] = 1;
						search_ptr = (idx + 1 == n) ? 0 : idx + 1;
						o.frame_addr = pfba_pkg::ADDR_BITS'(longint'(idx) * pfba_pkg::PAGE_BYTES);
						o.status = 1'b0;
						break;
					end
				end
			end
			pfba_pkg::K_ALLOC_RUN: begin
				if (cnt != 0) begin
					o.status = 1'b1;
					run = 0;
					rs = 0;
					for (int unsigned i = 0; i < n; i++) begin
						if (used_map[i]) begin
							run = 0;
						end else begin
							if (run == 0) rs = i;
							run++;
							if (run == cnt) begin
								for (int unsigned j = rs; j < rs + cnt; j++) used_map[j] = 1;
								search_ptr = rs + cnt;
								o.frame_addr =
									pfba_pkg::ADDR_BITS'(longint'(rs) * pfba_pkg::PAGE_BYTES);
								o.status = 1'b0;
								break;
							end
						end
					end
				end
			end
			pfba_pkg::K_FREE_RANGE: begin
				for (int unsigned i = 0; i < cnt; i++)
					if (base + i < n) used_map[base + i] = 0;
			end
			default: ;
		endcase
		return o;
	endfunction

	always @(posedge clk) begin
		pfba_pkg::res_t e;
		if (arst_n && done) begin
			if (expected_res.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				e = expected_res.pop_front();
				if (res.frame_addr !== e.frame_addr) begin
					$error("frame_addr expected %h actual %h", e.frame_addr, res.frame_addr);
					errors++;
				end
				if (res.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, res.status);
					errors++;
				end
			end
		end
	end

	task automatic send_req(logic [pfba_pkg::KIND_W-1:0] kind,
			logic [pfba_pkg::ADDR_BITS-1:0] addr, logic [pfba_pkg::CNT_W-1:0] cnt);
		pfba_pkg::req_t r;
		int gap;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0) gap = 0;
		// start was just dropped; the block stays busy past this edge anyway
		@(posedge clk);
		repeat (gap) @(posedge clk);
		r.req_type = kind;
		r.phys_addr = addr;
		r.frame_count = cnt;
		expected_res.push_back(predict_alloc(r));
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		start <= 1'b0;
	endtask

	task automatic wait_idle();
		while (expected_res.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_tracked(int unsigned v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= pfba_pkg::CNT_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		tracked = v;
		@(posedge clk);
	endtask

	function automatic logic [pfba_pkg::ADDR_BITS-1:0] page_addr(int unsigned idx);
		return pfba_pkg::ADDR_BITS'(longint'(idx) * pfba_pkg::PAGE_BYTES) |
			pfba_pkg::ADDR_BITS'($urandom_range(0, pfba_pkg::PAGE_BYTES - 1));
	endfunction

	task automatic test_directed();
		write_tracked(pfba_pkg::MAX_FRAMES);
		send_req(pfba_pkg::K_ALLOC_ONE, 0, 0);
		send_req(pfba_pkg::K_ALLOC_RUN, 0, 1);
		send_req(pfba_pkg::K_FREE_RANGE, 0, 200);
		send_req(pfba_pkg::K_ALLOC_RUN, 0, 0);
		send_req(pfba_pkg::K_ALLOC_RUN, 0, 17'h10000);
		send_req(pfba_pkg::K_ALLOC_RUN, 0, 17'h1ffff);
		send_req(pfba_pkg::K_ALLOC_RUN, 0, 70);
		send_req(pfba_pkg::K_ALLOC_ONE, 48'hffff_ffff_ffff, 17'h1ffff);
		send_req(pfba_pkg::K_MARK_FREE, 48'hffff_ffff_ffff, 0);
		send_req(pfba_pkg::K_ALLOC_ONE, 0, 0);
		send_req(pfba_pkg::K_MARK_FREE, 48'h0fff_ffff_ffff, 0);
		send_req(pfba_pkg::K_MARK_USED, page_addr(3), 0);
		send_req(pfba_pkg::K_MARK_FREE, page_addr(3), 0);
		send_req(pfba_pkg::K_ALLOC_ONE, 0, 0);
		send_req(3'd5, 48'hffff_ffff_ffff, 17'h1ffff);
		send_req(3'd6, 0, 5);
		send_req(3'd7, page_addr(1), 1);
		send_req(pfba_pkg::K_FREE_RANGE, page_addr(65530), 17'h1ffff);
		send_req(pfba_pkg::K_ALLOC_RUN, 0, 6);
		write_tracked(0);
		send_req(pfba_pkg::K_ALLOC_ONE, 0, 0);
		send_req(pfba_pkg::K_ALLOC_RUN, 0, 1);
		send_req(pfba_pkg::K_MARK_FREE, 0, 0);
		write_tracked(1);
		send_req(pfba_pkg::K_MARK_FREE, 0, 0);
		send_req(pfba_pkg::K_ALLOC_ONE, 0, 0);
	endtask

	task automatic test_random(int unsigned items, int unsigned frames);
		int unsigned k, idx, c;
		logic [pfba_pkg::ADDR_BITS-1:0] a;
		write_tracked(frames);
		for (int unsigned i = 0; i < items; i++) begin
			k = $urandom_range(0, 99);
			idx = $urandom_range(0, frames + 64);
			a = page_addr(idx);
			c = $urandom_range(0, 40);
			if (k < 3) begin
				a = pfba_pkg::ADDR_BITS'({$urandom, $urandom});
				c = $urandom & 17'h1ffff;
				send_req(pfba_pkg::KIND_W'($urandom_range(0, 7)), a, pfba_pkg::CNT_W'(c));
			end else if (k < 20) send_req(pfba_pkg::K_MARK_USED, a, pfba_pkg::CNT_W'(c));
			else if (k < 35) send_req(pfba_pkg::K_MARK_FREE, a, pfba_pkg::CNT_W'(c));
			else if (k < 60) send_req(pfba_pkg::K_ALLOC_ONE, a, pfba_pkg::CNT_W'(c));
			else if (k < 80) send_req(pfba_pkg::K_ALLOC_RUN, a, pfba_pkg::CNT_W'(c));
			else send_req(pfba_pkg::K_FREE_RANGE, a, pfba_pkg::CNT_W'(c));
		end
	endtask

	initial begin
		start = 0;
		req = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		for (int i = 0; i < pfba_pkg::MAX_FRAMES; i++) used_map[i] = 1;
		search_ptr = 0;
		tracked = pfba_pkg::MAX_FRAMES;
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(140, 256);
		test_random(140, 1000);
		test_random(100, 70);
		test_random(100, 17'h1ffff);
		test_random(100, 8);
		wait_idle();
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
`default_nettype wire
